FILE: src/sliding_window_stats_unit_defines.svh
// ----------------------------------------------------------------------------
// Sliding window stats unit: assertion macros
// Shared property wrappers for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_STATS_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_STATS_UNIT_DEFINES_SVH

// checked outside reset only
`define SWS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked at every edge, reset included
`define SWS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sws_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window stats package
// Widths, constants, sequencer states and control struct.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = SAMPLE_W + IDX_W;
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int PROD_W     = 2 * DIFF_W - 1;
	localparam int ROOT_W     = (2 * DIFF_W - 2 + IDX_W + 1) / 2;
	localparam int ACC_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 1;
	localparam int SUB_W      = REM_W + 2;
	localparam int SEQ_W      = $clog2(MAX_WINDOW + SUM_W + ROOT_W);
	localparam int DIV_STEPS  = SUM_W;
	localparam int ROOT_STEPS = ROOT_W;

	localparam int WINLEN_W   = 5;
	localparam int SLOT_W     = 4;
	localparam int SPREAD_W   = 15;
	localparam int OUT_BITS   = 2 * WINLEN_W + SLOT_W + 3 * SAMPLE_W + SPREAD_W;
	localparam int M_DATA_W   = ((OUT_BITS + 7) / 8) * 8;
	localparam int S_DATA_W   = SAMPLE_W;

	localparam int ADDR_W     = 3;
	localparam int PDATA_W    = 32;

	localparam logic [0:0]            REG_WINDOW_LENGTH = 1'b0;
	localparam logic [WINLEN_W-1:0]   WINLEN_RESET      = WINLEN_W'(MAX_WINDOW);
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN   = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX   = 16'sh7FFF;
	localparam logic [SPREAD_W-1:0]   SPREAD_MAX        = 15'h7FFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_MEAN,
		ST_DEV,
		ST_DRAIN,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ready;
		logic init;
		logic scan;
		logic prep;
		logic div;
		logic mean;
		logic dev;
		logic root;
		logic load;
	} ctrl_t;

endpackage

FILE: src/sliding_window_stats_unit.sv
// ----------------------------------------------------------------------------
// Sliding window stats unit
// Ring of recent samples; per request reports fill, free space, next slot,
// truncated mean, max, min and root of summed squared deviations.
// ----------------------------------------------------------------------------
//  channel  | side   | payload
//  s_t*     | in     | tdata: sample
//  m_t*     | out    | tdata: fill_count .. spread_value
//  apb      | config | window_length at address 0
//
// From acceptance to the next ready, a request makes two passes of N entries
// over the ring's single read port, N being the fill count after the push, and
// takes 20 divide steps and 18 root steps on the shared subtractor.
// The result sits in an output register; a new request is taken while it waits,
// and the next result holds the sequencer in its last state until that drains.
// Reset sets window_length to 16 and empties the ring; no clearing pass.
module sliding_window_stats_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sws_pkg::S_DATA_W-1:0]       s_tdata,  // [15:0] sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [4:0] fill_count, [9:5] free_space, [13:10] next_slot, [29:14] mean_value,
	// [45:30] max_value, [61:46] min_value, [76:62] spread_value, rest zero
	output logic [sws_pkg::M_DATA_W-1:0]       m_tdata,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sws_pkg::ADDR_W-1:0]         paddr,
	input  logic [sws_pkg::PDATA_W-1:0]        pwdata,
	output logic [sws_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import sws_pkg::*;

	ctrl_t                      ctrl;
	logic [IDX_W-1:0]           idx;
	logic                       push;
	logic                       cfg_we;
	logic                       reg_hit;
	logic                       out_free;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic [WINLEN_W-1:0]        fill_count;
	logic [WINLEN_W-1:0]        free_space;
	logic [SLOT_W-1:0]          next_slot;
	logic [WINLEN_W-1:0]        win_len;
	logic signed [SAMPLE_W-1:0] mean_value;
	logic signed [SAMPLE_W-1:0] max_value;
	logic signed [SAMPLE_W-1:0] min_value;
	logic [SPREAD_W-1:0]        spread_value;
	logic                       m_tvalid_q;
	logic [M_DATA_W-1:0]        m_tdata_q;

	assign pready   = 1'b1;
	assign reg_hit  = (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH);
	assign cfg_we   = psel & penable & pwrite & pready & reg_hit;
	assign prdata   = reg_hit ? PDATA_W'(win_len) : '0;

	assign s_tready = ctrl.ready;
	assign push     = s_tvalid & ctrl.ready;
	assign out_free = !m_tvalid_q || m_tready;

	sws_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_len    (pwdata[WINLEN_W-1:0]),
		.push       (push),
		.sample     (s_tdata[SAMPLE_W-1:0]),
		.rd_idx     (idx),
		.rd_data    (rd_data),
		.fill_count (fill_count),
		.free_space (free_space),
		.next_slot  (next_slot),
		.win_len    (win_len)
	);

	sws_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_tvalid),
		.out_free   (out_free),
		.fill_count (fill_count),
		.ctrl       (ctrl),
		.idx        (idx)
	);

	sws_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.rd_data      (rd_data),
		.fill_count   (fill_count),
		.mean_value   (mean_value),
		.max_value    (max_value),
		.min_value    (min_value),
		.spread_value (spread_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			m_tdata_q <= M_DATA_W'({spread_value, min_value, max_value, mean_value,
			                        next_slot, free_space, fill_count});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: src/sws_ring.sv
// ----------------------------------------------------------------------------
// Sample ring
// Ring store, write slot, fill count and window length register.
// ----------------------------------------------------------------------------
module sws_ring (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sws_pkg::WINLEN_W-1:0]           cfg_len,
	input  logic                                   push,
	input  logic signed [sws_pkg::SAMPLE_W-1:0]    sample,
	input  logic [sws_pkg::IDX_W-1:0]              rd_idx,
	output logic signed [sws_pkg::SAMPLE_W-1:0]    rd_data,
	output logic [sws_pkg::WINLEN_W-1:0]           fill_count,
	output logic [sws_pkg::WINLEN_W-1:0]           free_space,
	output logic [sws_pkg::SLOT_W-1:0]             next_slot,
	output logic [sws_pkg::WINLEN_W-1:0]           win_len
);
	import sws_pkg::*;

	logic [WINLEN_W-1:0]        win_len_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [WINLEN_W-1:0]        count_q;
	logic signed [SAMPLE_W-1:0] store_q [MAX_WINDOW];

	logic [WINLEN_W-1:0] len;
	logic [SLOT_W-1:0]   wr_slot;
	logic [WINLEN_W-1:0] slot_inc;
	logic [SLOT_W-1:0]   slot_d;
	logic [WINLEN_W-1:0] count_d;

	always_comb begin
		if (win_len_q == '0) begin
			len = WINLEN_W'(1);
		end else if (win_len_q > WINLEN_W'(MAX_WINDOW)) begin
			len = WINLEN_W'(MAX_WINDOW);
		end else begin
			len = win_len_q;
		end
		wr_slot  = (WINLEN_W'(slot_q) >= len) ? '0 : slot_q;
		slot_inc = WINLEN_W'(wr_slot) + WINLEN_W'(1);
		slot_d   = (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
		count_d  = (count_q < len) ? count_q + WINLEN_W'(1) : len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= WINLEN_RESET;
			slot_q    <= '0;
			count_q   <= '0;
		end else if (cfg_we) begin
			win_len_q <= cfg_len;
			slot_q    <= '0;
			count_q   <= '0;
		end else if (push) begin
			slot_q    <= slot_d;
			count_q   <= count_d;
		end
	end

	// entries below the fill count are always written after the last clear
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_slot[IDX_W-1:0]] <= sample;
		end
	end

	assign rd_data    = store_q[rd_idx];
	assign fill_count = count_q;
	assign free_space = len - count_q;
	assign next_slot  = slot_q;
	assign win_len    = win_len_q;

endmodule

FILE: src/sws_seq.sv
// ----------------------------------------------------------------------------
// Sequencer
// Steps the shared unit through scan, divide, deviation and root phases.
// ----------------------------------------------------------------------------
module sws_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_valid,
	input  logic                          out_free,
	input  logic [sws_pkg::WINLEN_W-1:0]  fill_count,
	output sws_pkg::ctrl_t                ctrl,
	output logic [sws_pkg::IDX_W-1:0]     idx
);
	import sws_pkg::*;

	state_t           state_q, state_d;
	logic [SEQ_W-1:0] cnt_q, cnt_d;
	logic             last_entry;

	assign last_entry = (cnt_q == SEQ_W'(fill_count) - SEQ_W'(1));
	assign idx        = cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctrl    = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.ready = 1'b1;
				if (s_valid) begin
					ctrl.init = 1'b1;
					state_d   = ST_SCAN;
					cnt_d     = '0;
				end
			end
			ST_SCAN: begin
				ctrl.scan = 1'b1;
				if (last_entry) begin
					state_d = ST_PREP;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SEQ_W'(1);
				end
			end
			ST_PREP: begin
				ctrl.prep = 1'b1;
				state_d   = ST_DIV;
				cnt_d     = '0;
			end
			ST_DIV: begin
				ctrl.div = 1'b1;
				if (cnt_q == SEQ_W'(DIV_STEPS - 1)) begin
					state_d = ST_MEAN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SEQ_W'(1);
				end
			end
			ST_MEAN: begin
				ctrl.mean = 1'b1;
				state_d   = ST_DEV;
				cnt_d     = '0;
			end
			ST_DEV: begin
				ctrl.dev = 1'b1;
				if (last_entry) begin
					state_d = ST_DRAIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SEQ_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_ROOT;
				cnt_d   = '0;
			end
			ST_ROOT: begin
				ctrl.root = 1'b1;
				if (cnt_q == SEQ_W'(ROOT_STEPS - 1)) begin
					state_d = ST_DONE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SEQ_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ctrl.load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

endmodule

FILE: src/sws_calc.sv
// ----------------------------------------------------------------------------
// Statistics datapath
// Sum, min and max scan, shared subtractor for restoring divide and
// square root, squared deviation multiply-accumulate.
// ----------------------------------------------------------------------------
module sws_calc (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sws_pkg::ctrl_t                       ctrl,
	input  logic signed [sws_pkg::SAMPLE_W-1:0]  rd_data,
	input  logic [sws_pkg::WINLEN_W-1:0]         fill_count,
	output logic signed [sws_pkg::SAMPLE_W-1:0]  mean_value,
	output logic signed [sws_pkg::SAMPLE_W-1:0]  max_value,
	output logic signed [sws_pkg::SAMPLE_W-1:0]  min_value,
	output logic [sws_pkg::SPREAD_W-1:0]         spread_value
);
	import sws_pkg::*;

	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] mx_q;
	logic signed [SAMPLE_W-1:0] mn_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [SUM_W-1:0]           dvd_q;
	logic                       neg_q;
	logic [REM_W-1:0]           rem_q;
	logic [ROOT_W-1:0]          root_q;
	logic [ACC_W-1:0]           acc_q;
	logic [PROD_W-1:0]          prod_s1;
	logic                       prod_v_s1;

	logic [SUB_W-1:0]             sub_a;
	logic [SUB_W-1:0]             sub_b;
	logic [SUB_W:0]               sub_d;
	logic                         borrow;
	logic signed [DIFF_W-1:0]     diff;
	logic signed [2*DIFF_W-1:0]   sq_full;

	// shared subtract/compare: divisor trial or root trial
	always_comb begin
		if (ctrl.div) begin
			sub_a = SUB_W'({rem_q[CNT_W-1:0], dvd_q[SUM_W-1]});
			sub_b = SUB_W'(fill_count);
		end else begin
			sub_a = {rem_q, acc_q[ACC_W-1 -: 2]};
			sub_b = SUB_W'({root_q, 2'b01});
		end
		sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
		borrow = sub_d[SUB_W];
	end

	assign diff    = {rd_data[SAMPLE_W-1], rd_data} - {mean_q[SAMPLE_W-1], mean_q};
	assign sq_full = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= ctrl.dev;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			sum_q <= '0;
			mx_q  <= SAMPLE_MIN;
			mn_q  <= SAMPLE_MAX;
		end
		if (ctrl.scan) begin
			sum_q <= sum_q + {{IDX_W{rd_data[SAMPLE_W-1]}}, rd_data};
			if (rd_data > mx_q) begin
				mx_q <= rd_data;
			end
			if (rd_data < mn_q) begin
				mn_q <= rd_data;
			end
		end

		if (ctrl.prep) begin
			neg_q <= sum_q[SUM_W-1];
			dvd_q <= sum_q[SUM_W-1] ? -sum_q : sum_q;
			rem_q <= '0;
		end else if (ctrl.div) begin
			rem_q <= REM_W'(borrow ? sub_a[CNT_W-1:0] : sub_d[CNT_W-1:0]);
			dvd_q <= {dvd_q[SUM_W-2:0], ~borrow};
		end else if (ctrl.mean) begin
			rem_q <= '0;
		end else if (ctrl.root) begin
			rem_q <= borrow ? sub_a[REM_W-1:0] : sub_d[REM_W-1:0];
		end

		if (ctrl.mean) begin
			mean_q <= neg_q ? SAMPLE_W'(-dvd_q) : SAMPLE_W'(dvd_q);
			root_q <= '0;
		end else if (ctrl.root) begin
			root_q <= {root_q[ROOT_W-2:0], ~borrow};
		end

		if (ctrl.dev) begin
			prod_s1 <= PROD_W'(sq_full);
		end

		if (ctrl.mean) begin
			acc_q <= '0;
		end else if (ctrl.root) begin
			acc_q <= {acc_q[ACC_W-3:0], 2'b00};
		end else if (prod_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign mean_value   = mean_q;
	assign max_value    = mx_q;
	assign min_value    = mn_q;
	assign spread_value = (root_q[ROOT_W-1:SPREAD_W] != '0) ? SPREAD_MAX
	                                                       : root_q[SPREAD_W-1:0];

endmodule

FILE: src/sws_check.sv
// ----------------------------------------------------------------------------
// Sliding window stats checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_stats_unit_defines.svh"

module sws_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sws_pkg::M_DATA_W-1:0]  m_tdata
);
	import sws_pkg::*;

	`SWS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`SWS_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready right after a request")
	`SWS_ASSERT(a_fill_range, m_tvalid |-> m_tdata[4:0] != 5'd0 && (m_tdata[4:0] + m_tdata[9:5]) <= MAX_WINDOW, "fill or free space out of range")
	`SWS_ASSERT(a_order, m_tvalid |-> $signed(m_tdata[61:46]) <= $signed(m_tdata[29:14]) && $signed(m_tdata[29:14]) <= $signed(m_tdata[45:30]), "mean outside min and max")
	`SWS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind sliding_window_stats_unit sws_check u_sws_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sliding_window_stats_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window stats unit testbench
// Pushes signed samples through the stream input under random bursts, gaps
// and output back-pressure. A local ring predicts fill, free space, next slot,
// truncated mean, max, min and saturated spread for every request, and each
// output request is compared field by field. The window length register is
// rewritten between phases across its whole 5-bit range, and an unmapped
// register write is checked for having no effect.
// ----------------------------------------------------------------------------
module sliding_window_stats_unit_tb;
	import sws_pkg::*;

	localparam int OUT_W      = 2 * WINLEN_W + SLOT_W + 3 * SAMPLE_W + SPREAD_W;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_WAIT  = 100;
	localparam int PHASE_ITEMS = 110;
	localparam logic [ADDR_W-1:0] WINLEN_ADDR = ADDR_W'(4 * REG_WINDOW_LENGTH);
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

	typedef struct packed {
		logic [SPREAD_W-1:0]        spread;
		logic signed [SAMPLE_W-1:0] min_v;
		logic signed [SAMPLE_W-1:0] max_v;
		logic signed [SAMPLE_W-1:0] mean_v;
		logic [SLOT_W-1:0]          slot;
		logic [WINLEN_W-1:0]        free;
		logic [WINLEN_W-1:0]        fill;
	} stats_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // [15:0] sample
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// [4:0] fill_count, [9:5] free_space, [13:10] next_slot, [29:14] mean_value,
	// [45:30] max_value, [61:46] min_value, [76:62] spread_value, rest zero
	logic [M_DATA_W-1:0] m_tdata;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// window model
	logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
	int                         ring_slot;
	int                         ring_count;
	logic [WINLEN_W-1:0]        win_len;

	logic signed [SAMPLE_W-1:0] sample_q [$];
	stats_t                     stats_q [$];

	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int gap_left = 0;
	logic [31:0] ready_bits = '1;
	int ready_hold = 0;
	int idle_cycles = 0;
	stats_t got;
	stats_t want;

	sliding_window_stats_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	function automatic void clear_window();
		for (int i = 0; i < MAX_WINDOW; i++) ring[i] = '0;
		ring_slot = 0;
		ring_count = 0;
	endfunction

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
		int len;
		int total;
		int mean_i;
		int hi;
		int lo;
		longint acc;
		longint diff;
		longint root;
		longint trial;
		stats_t res;
		len = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
		if (ring_slot >= len) ring_slot = 0;
		ring[ring_slot] = smp;
		ring_slot++;
		if (ring_slot >= len) ring_slot = 0;
		if (ring_count < len) ring_count++;
		total = 0;
		hi = -32768;
		lo = 32767;
		for (int i = 0; i < ring_count; i++) begin
			total += ring[i];
			if (ring[i] > hi) hi = ring[i];
			if (ring[i] < lo) lo = ring[i];
		end
		mean_i = total / ring_count;
		acc = 0;
		for (int i = 0; i < ring_count; i++) begin
			diff = longint'(ring[i]) - longint'(mean_i);
			acc += diff * diff;
		end
		root = 0;
		for (int b = 19; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= acc) root = trial;
		end
		res.fill = WINLEN_W'(ring_count);
		res.free = WINLEN_W'(len - ring_count);
		res.slot = SLOT_W'(ring_slot);
		res.mean_v = SAMPLE_W'(mean_i);
		res.max_v = SAMPLE_W'(hi);
		res.min_v = SAMPLE_W'(lo);
		res.spread = (root > 32767) ? SPREAD_MAX : SPREAD_W'(root);
		stats_q.push_back(res);
	endtask

	function automatic void report_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			errors++;
			if (errors <= 50)
				$display("%0t ns: %s expected %0d got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			5, 6: return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
			7: return SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
			default: return $urandom_range(0, 1) ? SAMPLE_W'(32767 - $urandom_range(0, 15))
				: SAMPLE_W'(-32768 + int'($urandom_range(0, 15)));
		endcase
	endfunction

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		if (addr == WINLEN_ADDR) begin
			win_len = data[WINLEN_W-1:0];
			clear_window();
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sample_q.size() != 0 || s_tvalid || stats_q.size() != 0);
	endtask

	// sample driver: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				push_sample(s_tdata);
				samples_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= sample_q.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 110);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_bits = '1;
			ready_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = stats_t'(m_tdata[OUT_W-1:0]);
				if (stats_q.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected request, expected none got %h", $time, m_tdata);
				end else begin
					want = stats_q.pop_front();
					report_field("fill_count", want.fill, got.fill);
					report_field("free_space", want.free, got.free);
					report_field("next_slot", want.slot, got.slot);
					report_field("mean_value", want.mean_v, got.mean_v);
					report_field("max_value", want.max_v, got.max_v);
					report_field("min_value", want.min_v, got.min_v);
					report_field("spread_value", want.spread, got.spread);
					report_field("tdata padding", 0, int'(m_tdata[M_DATA_W-1:OUT_W]));
				end
			end
			if (ready_hold == 0) begin
				case ($urandom_range(0, 3))
					0: ready_bits = '1;
					1: ready_bits = $urandom;
					2: ready_bits = 32'h1 << $urandom_range(0, 31);
					default: ready_bits = $urandom | $urandom;
				endcase
				ready_hold = $urandom_range(40, 400);
			end else begin
				ready_hold--;
			end
			ready_bits = {ready_bits[30:0], ready_bits[31]};
			m_tready <= ready_bits[0];
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [WINLEN_W-1:0] lengths [12];
		win_len = WINLEN_RESET;
		clear_window();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// full-scale values, then alternating extremes to wrap the default ring
		sample_q.push_back(16'sd0);
		sample_q.push_back(SAMPLE_MAX);
		sample_q.push_back(SAMPLE_MIN);
		sample_q.push_back(-16'sd1);
		sample_q.push_back(16'sd1);
		sample_q.push_back(16'h5555);
		sample_q.push_back(16'hAAAA);
		for (int i = 0; i < 14; i++) sample_q.push_back(i[0] ? SAMPLE_MAX : SAMPLE_MIN);
		wait_drained();

		// unmapped register: ring contents must survive
		apb_write(UNMAPPED_ADDR, 32'h0000_0003);
		sample_q.push_back(16'sd100);
		sample_q.push_back(-16'sd100);
		sample_q.push_back(16'sd7);
		wait_drained();

		// 0 behaves as 1, above 16 behaves as 16
		lengths = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
		for (int p = 6; p < 12; p++)
			lengths[p] = ($urandom_range(0, 4) == 0) ? WINLEN_W'($urandom_range(0, 31))
				: WINLEN_W'($urandom_range(1, 16));
		for (int p = 0; p < 12; p++) begin
			apb_write(WINLEN_ADDR, {(PDATA_W - WINLEN_W)'($urandom), lengths[p]});
			for (int i = 0; i < PHASE_ITEMS; i++) sample_q.push_back(pick_sample());
			wait_drained();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (stats_q.size() != 0) begin
			errors++;
			$display("%0t ns: %0d requests never arrived", $time, stats_q.size());
		end
		$display("Pushed %0d samples, checked %0d results, %0d register writes", samples_sent,
			results_seen, reg_writes);
		$display("Window lengths covered 0, 1, 2, 16, 17, 31 and random; %0d mismatches", errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
